/* rtl/gray_sketch_pixel_filter_core_macros.svh */
// ----------------------------------------------------------------------------
// gray_sketch_pixel_filter_core_macros
// Assertion shorthands for the sketch filter core, clocked on clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef GRAY_SKETCH_PIXEL_FILTER_CORE_MACROS_SVH
`define GRAY_SKETCH_PIXEL_FILTER_CORE_MACROS_SVH

// Condition must hold at every edge outside reset
`define GSP_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define GSP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define GSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/gsp_pkg.sv */
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared constants and types of the gray sketch pixel filter.
// ----------------------------------------------------------------------------
package gsp_pkg;

   // Line geometry
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // Configuration registers
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
   localparam logic [WIDTH_W-1:0]    WIDTH_RESET      = 11'd1024;
   localparam logic [HEIGHT_W-1:0]   HEIGHT_RESET     = 13'd768;

   // Common width for the end-of-row compare
   localparam int CMP_W = (WIDTH_W > COL_W + 1) ? WIDTH_W : COL_W + 1;

   // Pixel and square root widths
   localparam int PIX_W  = 8;
   localparam int RAD_W  = 32;
   localparam int ROOT_W = RAD_W / 2;

   // Status of the serial square root unit
   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_stat_type;

endpackage

/* rtl/gsp_isqrt.sv */
// ----------------------------------------------------------------------------
// gsp_isqrt
// Bit-serial floor square root: two radicand bits in, one root bit out per
// cycle. A start loads the radicand; done pulses when the root is final.
// ----------------------------------------------------------------------------
module gsp_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gsp_pkg::RAD_W-1:0]     radicand,
   output logic [gsp_pkg::ROOT_W-1:0]    root,
   output gsp_pkg::sqrt_stat_type        stat
);

   localparam int REM_W  = gsp_pkg::ROOT_W + 2;
   localparam int WORK_W = gsp_pkg::ROOT_W + 4;
   localparam int CNT_W  = $clog2(gsp_pkg::ROOT_W + 1);

   logic [gsp_pkg::RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [gsp_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       done_ff, done_in;

   logic [WORK_W-1:0] work;
   logic [WORK_W-1:0] trial;
   logic [WORK_W-1:0] diff;
   logic              fits;

   // One restoring step: bring down two bits, try 4*root+1
   always_comb begin
      work  = {rem_ff, rad_ff[gsp_pkg::RAD_W-1 -: 2]};
      trial = {2'b00, root_ff, 2'b01};
      fits  = (work >= trial);
      diff  = work - trial;
   end

   // Load on start, else step while bits remain
   always_comb begin
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
         count_in = CNT_W'(gsp_pkg::ROOT_W);
      end else if (count_ff != '0) begin
         rad_in   = {rad_ff[gsp_pkg::RAD_W-3:0], 2'b00};
         rem_in   = fits ? diff[REM_W-1:0] : work[REM_W-1:0];
         root_in  = {root_ff[gsp_pkg::ROOT_W-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         done_in  = (count_ff == CNT_W'(1));
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root      = root_ff;
   assign stat.busy = (count_ff != '0);
   assign stat.done = done_ff;

endmodule

/* rtl/gray_sketch_pixel_filter_core.sv */
// ----------------------------------------------------------------------------
// gray_sketch_pixel_filter_core
// Requests: one at a time; req_tready is low from accept until the result
//   is loaded into the output registers, and stays low while a held result
//   waits on rsp_tready. A third square root runs only when s > 32768; the
//   two or three 16-step roots run on one shared bit-serial square root
//   unit.
// Reset: synchronous, active high; counters cleared, min 255, max 0, width
//   1024, height 768. Line store and left pixel hold no reset value.
// Pencil-sketch curve per pixel with running frame min and max.
// ----------------------------------------------------------------------------
`include "gray_sketch_pixel_filter_core_macros.svh"

module gray_sketch_pixel_filter_core (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] pixel
   // Result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,  // [7:0] sketch_value,
                                                          // [15:8] frame_min,
                                                          // [23:16] frame_max
   output logic                              rsp_tlast,  // last_of_frame
   // Configuration
   input  logic                              csr_we,
   input  logic [gsp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [gsp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int COL_W  = gsp_pkg::COL_W;
   localparam int ROW_W  = gsp_pkg::ROW_W;
   localparam int CMP_W  = gsp_pkg::CMP_W;
   localparam int HGT_W  = gsp_pkg::HEIGHT_W;
   localparam int PIX_W  = gsp_pkg::PIX_W;
   localparam int RAD_W  = gsp_pkg::RAD_W;
   localparam int ROOT_W = gsp_pkg::ROOT_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DIFF   = 3'd1;
   localparam logic [2:0] S_ROOT_G = 3'd2;
   localparam logic [2:0] S_ROOT_S = 3'd3;
   localparam logic [2:0] S_BRANCH = 3'd4;
   localparam logic [2:0] S_ROOT_H = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0]                     state_ff, state_in;
   logic [gsp_pkg::WIDTH_W-1:0]    width_ff;
   logic [gsp_pkg::HEIGHT_W-1:0]   height_ff;
   logic [COL_W-1:0]               col_ff, col_in;
   logic [ROW_W-1:0]               row_ff, row_in;
   logic [PIX_W-1:0]               min_ff, min_in;
   logic [PIX_W-1:0]               max_ff, max_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [PIX_W-1:0]               line_mem [gsp_pkg::MAX_WIDTH];
   logic [PIX_W-1:0]               pix_ff;
   logic [PIX_W-1:0]               left_ff;
   logic [PIX_W-1:0]               above_ff;
   logic [ROOT_W-1:0]              s_ff;
   logic [ROOT_W-1:0]              h_ff, h_in;
   logic [PIX_W-1:0]               rsp_value_ff;
   logic [PIX_W-1:0]               rsp_min_ff;
   logic [PIX_W-1:0]               rsp_max_ff;
   logic                           rsp_last_ff;

   logic                           accept;
   logic                           out_free;
   logic                           finish_go;
   logic                           sq_start;
   logic [RAD_W-1:0]               sq_rad;
   logic [ROOT_W-1:0]              sq_root;
   gsp_pkg::sqrt_stat_type         sq_stat;

   logic [PIX_W-1:0]               dx, dy;
   logic [2*PIX_W:0]               sumsq;
   logic [ROOT_W+2:0]              t_acc;
   logic                           s_above;
   logic [2*ROOT_W-1:0]            s_sq;
   logic [ROOT_W:0]                inv_h;
   logic [PIX_W-1:0]               value;
   logic [CMP_W-1:0]               w_eff;
   logic [HGT_W-1:0]               h_eff;
   logic                           row_end, frame_end;
   logic                           in_root_wait;
   logic                           rsp_in_range;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign finish_go  = (state_ff == S_FINISH) && out_free;

   // Clamp the configured geometry
   always_comb begin
      if (width_ff == '0) begin
         w_eff = CMP_W'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(gsp_pkg::MAX_WIDTH)) begin
         w_eff = CMP_W'(gsp_pkg::MAX_WIDTH);
      end else begin
         w_eff = CMP_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HGT_W'(1);
      end else if (height_ff > HGT_W'(gsp_pkg::MAX_HEIGHT)) begin
         h_eff = HGT_W'(gsp_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      row_end   = (CMP_W'(col_ff) + CMP_W'(1)) >= w_eff;
      frame_end = row_end && ((HGT_W'(row_ff) + HGT_W'(1)) >= h_eff);
   end

   // Gradients against the pixel above and the left pixel
   always_comb begin
      dx = '0;
      dy = '0;
      if (row_ff != '0) begin
         dx = (pix_ff > above_ff) ? pix_ff - above_ff : above_ff - pix_ff;
      end
      if (col_ff != '0) begin
         dy = (pix_ff > left_ff) ? pix_ff - left_ff : left_ff - pix_ff;
      end
      sumsq = (2*PIX_W+1)'((2*PIX_W)'(dx) * (2*PIX_W)'(dx))
            + (2*PIX_W+1)'((2*PIX_W)'(dy) * (2*PIX_W)'(dy));
   end

   // Tone term: 65536 - 256*p + 3*g, never negative
   assign t_acc = (ROOT_W+3)'(65536) - (ROOT_W+3)'({pix_ff, 8'h00})
                + (ROOT_W+3)'(sq_root) + (ROOT_W+3)'({sq_root, 1'b0});

   assign s_above = s_ff[ROOT_W-1] && (s_ff[ROOT_W-2:0] != '0);
   assign s_sq    = (2*ROOT_W)'(s_ff) * (2*ROOT_W)'(s_ff);

   // Output value: (65536 - h) >> 8, saturated to 255
   always_comb begin
      inv_h = (ROOT_W+1)'(65536) - (ROOT_W+1)'(h_ff);
      value = inv_h[ROOT_W] ? 8'hFF : inv_h[ROOT_W-1 -: PIX_W];
   end

   // Square root requests from the sequencer
   always_comb begin
      sq_start = 1'b0;
      sq_rad   = '0;
      case (state_ff)
         S_DIFF: begin
            sq_start = 1'b1;
            sq_rad   = {sumsq, 15'h0000};
         end
         S_ROOT_G: begin
            sq_start = sq_stat.done;
            sq_rad   = {t_acc[ROOT_W+1:2], 16'h0000};
         end
         S_BRANCH: begin
            sq_start = s_above;
            sq_rad   = {2'b00, s_ff[ROOT_W-2:0], 15'h0000};
         end
         default: begin
            sq_start = 1'b0;
         end
      endcase
   end

   gsp_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .root     (sq_root),
      .stat     (sq_stat)
   );

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      h_in     = h_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_DIFF;
         end
         S_DIFF: begin
            state_in = S_ROOT_G;
         end
         S_ROOT_G: begin
            if (sq_stat.done) state_in = S_ROOT_S;
         end
         S_ROOT_S: begin
            if (sq_stat.done) state_in = S_BRANCH;
         end
         S_BRANCH: begin
            if (s_above) begin
               state_in = S_ROOT_H;
            end else begin
               h_in     = s_sq[2*ROOT_W-2 -: ROOT_W];
               state_in = S_FINISH;
            end
         end
         S_ROOT_H: begin
            if (sq_stat.done) begin
               h_in     = sq_root + ROOT_W'(32768);
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Frame counters and running extremes
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (finish_go) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
            min_in = 8'hFF;
            max_in = 8'h00;
         end else begin
            min_in = (value < min_ff) ? value : min_ff;
            max_in = (value > max_ff) ? value : max_ff;
            if (row_end) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end
   end

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= gsp_pkg::WIDTH_RESET;
         height_ff    <= gsp_pkg::HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         min_ff       <= 8'hFF;
         max_ff       <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               gsp_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[gsp_pkg::WIDTH_W-1:0];
               gsp_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
               default: begin
                  width_ff <= width_ff;
               end
            endcase
         end
      end
   end

   // Line store: read the column at accept, write it back in the S_DIFF state
   always_ff @(posedge clock) begin
      above_ff <= line_mem[col_ff];
      if (state_ff == S_DIFF) begin
         line_mem[col_ff] <= pix_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff <= req_tdata;
      end
      if (state_ff == S_DIFF) begin
         left_ff <= pix_ff;
      end
      if ((state_ff == S_ROOT_S) && sq_stat.done) begin
         s_ff <= sq_root;
      end
      h_ff <= h_in;
      if (finish_go) begin
         rsp_value_ff <= value;
         rsp_min_ff   <= (value < min_ff) ? value : min_ff;
         rsp_max_ff   <= (value > max_ff) ? value : max_ff;
         rsp_last_ff  <= frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_max_ff, rsp_min_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   assign in_root_wait = (state_ff == S_ROOT_G) || (state_ff == S_ROOT_S)
                      || (state_ff == S_ROOT_H);
   assign rsp_in_range = (rsp_min_ff <= rsp_value_ff) && (rsp_value_ff <= rsp_max_ff);

   `GSP_ASSERT_IMPLIES(a_root_done_in_wait, sq_stat.done, in_root_wait, "stray root done")
   `GSP_ASSERT_IMPLIES(a_start_when_free, sq_start, !sq_stat.busy, "root started while busy")
   `GSP_ASSERT_IMPLIES(a_result_in_range, rsp_valid_ff, rsp_in_range, "result out of range")
   `GSP_ASSERT_NEXT(a_finish_loads, finish_go, rsp_valid_ff && req_tready, "result not presented")

endmodule
